### rtl/fecc_pkg.sv
// Package for the elevator car controller: sizes, payload structs, queue entry.
// No dependencies.
`timescale 1ns / 1ps
package fecc_pkg;
	localparam int REQUEST_DEPTH = 16;
	localparam int CABIN_SLOTS = 8;
	localparam int RQ_AW = $clog2(REQUEST_DEPTH);
	localparam int RQ_CW = $clog2(REQUEST_DEPTH + 1);
	localparam int CB_AW = (CABIN_SLOTS > 1) ? $clog2(CABIN_SLOTS) : 1;
	localparam logic [15:0] COUNTER_MAX = 16'hFFFF;
	localparam logic [1:0] DIR_STAY = 2'd0;
	localparam logic [1:0] DIR_UP = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;
	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] from_floor;
		logic [7:0] to_floor;
	} in_item_t;

	typedef struct packed {
		logic        request_accepted;
		logic [7:0]  current_floor;
		logic [1:0]  move_dir;
		logic [3:0]  riders_aboard;
		logic [4:0]  requests_waiting;
		logic [3:0]  exited_now;
		logic [3:0]  boarded_now;
		logic [15:0] served_total;
		logic [15:0] floors_total;
	} out_item_t;

	// Entry of the command queue between front and back.
	typedef struct packed {
		logic       command;
		logic [7:0] from_floor;
		logic [7:0] to_floor;
	} cmd_t;
endpackage

### rtl/fecc_cmd_queue.sv
// Two-entry command queue between the front and the back of the controller.
// Depends on fecc_pkg.
`timescale 1ns / 1ps
module fecc_cmd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  fecc_pkg::cmd_t  wr_data,
	output logic            rd_valid,
	input  logic            rd_ready,
	output fecc_pkg::cmd_t  rd_data
);
	import fecc_pkg::*;
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= ~wp_q;
			if (rd_valid && rd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !(rd_valid && rd_ready)) |=> cnt_q == 2'd2)
		else $error("full queue lost an entry");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !rd_valid)
		else $error("empty queue shows data");
endmodule

### rtl/fecc_front.sv
// Front end: takes input transfers and passes them as commands to the queue.
// Depends on fecc_pkg.
`timescale 1ns / 1ps
module fecc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fecc_pkg::in_item_t in_data,
	output logic              cq_valid,
	input  logic              cq_ready,
	output fecc_pkg::cmd_t    cq_data
);
	import fecc_pkg::*;
	logic vld_q;
	cmd_t cmd_q;

	assign in_ready = !vld_q || cq_ready;
	assign cq_valid = vld_q;
	assign cq_data = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	// Any command bit other than a request is a tick.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q.command <= (in_data.command == CMD_REQUEST) ? CMD_REQUEST : CMD_TICK;
			cmd_q.from_floor <= in_data.from_floor;
			cmd_q.to_floor <= in_data.to_floor;
		end
	end
endmodule

### rtl/fecc_back.sv
// Back end: car state, rider list and request FIFO; executes one command at a time.
// Depends on fecc_pkg.
`timescale 1ns / 1ps
module fecc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         cabin_capacity,
	input  logic               cq_valid,
	output logic               cq_ready,
	input  fecc_pkg::cmd_t     cq_data,
	output logic               out_valid,
	input  logic               out_ready,
	output fecc_pkg::out_item_t out_data
);
	import fecc_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_UNLOAD, ST_RDREQ, ST_BOARD, ST_TARGET, ST_RESULT}
		state_t;
	state_t state_q;

	logic [7:0] rider_q [CABIN_SLOTS];
	logic [15:0] fifo_q [REQUEST_DEPTH];
	logic [7:0] floor_q;
	logic [CB_AW:0] rcnt_q, rkeep_q, ri_q;
	logic [RQ_CW-1:0] qcnt_q, qkeep_q, qi_q;
	logic [15:0] served_q, floors_q;
	logic [3:0] exited_q, boarded_q;
	logic [1:0] dir_q;
	logic acc_q;
	logic [15:0] rd_s1;
	logic [CB_AW:0] cap;
	logic [7:0] target;

	always_comb begin
		if (cabin_capacity > 4'(CABIN_SLOTS)) cap = (CB_AW + 1)'(CABIN_SLOTS);
		else cap = (CB_AW + 1)'(cabin_capacity);
	end

	always_comb begin
		if (rcnt_q != '0) target = rider_q[0];
		else if (qcnt_q != '0) target = rd_s1[15:8];
		else target = floor_q;
	end

	assign cq_ready = (state_q == ST_IDLE) && !out_valid;

	// Request FIFO memory: one write port, one registered read port.
	logic fifo_we;
	logic [RQ_AW-1:0] fifo_wa, fifo_ra;
	logic [15:0] fifo_wd;
	always_comb begin
		fifo_we = 1'b0;
		fifo_wa = qcnt_q[RQ_AW-1:0];
		fifo_wd = {cq_data.from_floor, cq_data.to_floor};
		fifo_ra = qi_q[RQ_AW-1:0];
		if (state_q == ST_IDLE && cq_valid && cq_ready && cq_data.command == CMD_REQUEST
				&& qcnt_q != RQ_CW'(REQUEST_DEPTH)) begin
			fifo_we = 1'b1;
		end else if (state_q == ST_BOARD && !(rd_s1[15:8] == floor_q && rcnt_q < cap)) begin
			fifo_we = 1'b1;
			fifo_wa = qkeep_q[RQ_AW-1:0];
			fifo_wd = rd_s1;
		end
		if (state_q == ST_BOARD && qi_q + 1'b1 == qcnt_q) fifo_ra = '0;
		else if (state_q == ST_BOARD) fifo_ra = RQ_AW'(qi_q + 1'b1);
	end
	always_ff @(posedge clk) begin
		if (fifo_we) fifo_q[fifo_wa] <= fifo_wd;
		rd_s1 <= (fifo_we && fifo_wa == fifo_ra) ? fifo_wd : fifo_q[fifo_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UNLOAD && ri_q < rcnt_q && rider_q[ri_q[CB_AW-1:0]] != floor_q)
			rider_q[rkeep_q[CB_AW-1:0]] <= rider_q[ri_q[CB_AW-1:0]];
		if (state_q == ST_BOARD && rd_s1[15:8] == floor_q && rcnt_q < cap)
			rider_q[rcnt_q[CB_AW-1:0]] <= rd_s1[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			floor_q <= '0;
			rcnt_q <= '0;
			qcnt_q <= '0;
			served_q <= '0;
			floors_q <= '0;
			rkeep_q <= '0;
			ri_q <= '0;
			qkeep_q <= '0;
			qi_q <= '0;
			exited_q <= '0;
			boarded_q <= '0;
			dir_q <= DIR_STAY;
			acc_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cq_valid && cq_ready) begin
						exited_q <= '0;
						boarded_q <= '0;
						dir_q <= DIR_STAY;
						acc_q <= 1'b1;
						ri_q <= '0;
						rkeep_q <= '0;
						qi_q <= '0;
						qkeep_q <= '0;
						if (cq_data.command == CMD_REQUEST) begin
							if (qcnt_q == RQ_CW'(REQUEST_DEPTH)) acc_q <= 1'b0;
							else qcnt_q <= qcnt_q + 1'b1;
							state_q <= ST_RESULT;
						end else if (rcnt_q == '0 && qcnt_q == '0) begin
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_UNLOAD;
						end
					end
				end
				ST_UNLOAD: begin
					if (ri_q < rcnt_q) begin
						if (rider_q[ri_q[CB_AW-1:0]] == floor_q) begin
							exited_q <= exited_q + 1'b1;
							if (served_q != COUNTER_MAX) served_q <= served_q + 1'b1;
						end else begin
							rkeep_q <= rkeep_q + 1'b1;
						end
						ri_q <= ri_q + 1'b1;
					end else begin
						rcnt_q <= rkeep_q;
						state_q <= (qcnt_q == '0) ? ST_TARGET : ST_RDREQ;
					end
				end
				ST_RDREQ: state_q <= ST_BOARD;  // read of entry 0 is in flight
				ST_BOARD: begin
					if (rd_s1[15:8] == floor_q && rcnt_q < cap) begin
						rcnt_q <= rcnt_q + 1'b1;
						boarded_q <= boarded_q + 1'b1;
					end else begin
						qkeep_q <= qkeep_q + 1'b1;
					end
					qi_q <= qi_q + 1'b1;
					if (qi_q + 1'b1 == qcnt_q) state_q <= ST_TARGET;
				end
				ST_TARGET: begin
					// The read data now holds the oldest entry left, if any.
					if (qi_q != '0) qcnt_q <= qkeep_q;
					if (qi_q != '0 && qkeep_q == '0 && rcnt_q == '0) begin
						dir_q <= DIR_STAY;
					end else if (target > floor_q) begin
						floor_q <= floor_q + 1'b1;
						dir_q <= DIR_UP;
						if (floors_q != COUNTER_MAX) floors_q <= floors_q + 1'b1;
					end else if (target < floor_q) begin
						floor_q <= floor_q - 1'b1;
						dir_q <= DIR_DOWN;
						if (floors_q != COUNTER_MAX) floors_q <= floors_q + 1'b1;
					end
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		out_data.request_accepted = acc_q;
		out_data.current_floor = floor_q;
		out_data.move_dir = dir_q;
		out_data.riders_aboard = 4'(rcnt_q);
		out_data.requests_waiting = 5'(qcnt_q);
		out_data.exited_now = exited_q;
		out_data.boarded_now = boarded_q;
		out_data.served_total = served_q;
		out_data.floors_total = floors_q;
	end

	a_riders: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= (CB_AW + 1)'(CABIN_SLOTS)) else $error("rider count overflow");
	a_reqs: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= RQ_CW'(REQUEST_DEPTH)) else $error("request count overflow");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(cq_valid && cq_ready) |=> state_q != ST_IDLE) else $error("command not started");
	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TARGET && dir_q != DIR_STAY) |-> 1'b0 || dir_q == DIR_STAY)
		else $error("direction not cleared");
endmodule

### rtl/fifo_elevator_car_controller.sv
// Top level of the elevator car controller: front, command queue, back, capacity register.
// Depends on fecc_pkg, fecc_front, fecc_cmd_queue, fecc_back.
// A request or an idle tick goes straight to the result. Any other tick runs the serial
// unload scan in the back, and with waiting requests also the board scan.
// The back takes a new command only after its last result has been transferred.
// Reset clears the car state and counters and sets the capacity to 4.
`timescale 1ns / 1ps
module fifo_elevator_car_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  fecc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output fecc_pkg::out_item_t out_data
);
	import fecc_pkg::*;
	logic [3:0] cap_q;
	logic f_valid, f_ready, b_valid, b_ready;
	cmd_t f_data, b_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= 4'd4;
		else if (cfg_we) cap_q <= cfg_wdata;
	end

	fecc_front u_front (.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.cq_valid(f_valid), .cq_ready(f_ready), .cq_data(f_data));
	fecc_cmd_queue u_queue (.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_data(f_data), .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data));
	fecc_back u_back (.clk, .arst_n, .cabin_capacity(cap_q), .cq_valid(b_valid),
		.cq_ready(b_ready), .cq_data(b_data), .out_valid, .out_ready, .out_data);
endmodule
